>>> rtl/dense_shortest_path_core_defines.svh
// assertion macros shared by the shortest path core
`ifndef DENSE_SHORTEST_PATH_CORE_DEFINES_SVH
`define DENSE_SHORTEST_PATH_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define DSP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dense_shortest_path_core: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define DSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dense_shortest_path_core: next-cycle check failed");

`endif

>>> rtl/dsp_pkg.sv
// shared types and constants of the shortest path core
package dsp_pkg;

   localparam int MAX_NODES_DEF = 64;
   localparam int IDX_W = 6;
   localparam int DIST_W = 28;
   localparam int CNT_W = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [DIST_W-1:0] NO_EDGE = 28'hfffffff;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_RUN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE = 2'd1;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_INIT,
      OP_CLEAR,
      OP_SCAN,
      OP_RELAX,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      logic load;
      dp_op_type op;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] src;
      logic last;
      logic ok;
   } dp_cmd_type;

   typedef struct packed {
      logic found;
   } dp_status_type;

   typedef struct packed {
      logic visited;
      logic pred_valid;
      logic [IDX_W-1:0] pred;
      logic [DIST_W-1:0] path_len;
   } node_entry_type;

endpackage

>>> rtl/dsp_ctrl.sv
// sequencer for loads, search passes and result emission
module dsp_ctrl #(
   parameter int MAX_NODES = dsp_pkg::MAX_NODES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               req_op,
   output logic                               busy,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dsp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  dsp_pkg::dp_status_type             status,
   output dsp_pkg::dp_cmd_type                cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_CLEAR,
      S_SCAN,
      S_WAIT,
      S_DECIDE,
      S_RELAX,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   dsp_pkg::dp_op_type op_ff, op_in;
   logic [dsp_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [dsp_pkg::IDX_W-1:0] nlast_ff, nlast_in;
   logic [dsp_pkg::IDX_W-1:0] src_ff, src_in;
   logic last_ff, last_in;
   logic ok_ff, ok_in;
   logic busy_ff, busy_in;

   logic [dsp_pkg::CNT_W-1:0] node_count_ff;
   logic [dsp_pkg::IDX_W-1:0] source_ff;

   logic accept;
   logic idx_end;
   logic [dsp_pkg::CNT_W-1:0] n_eff;
   logic [dsp_pkg::IDX_W-1:0] n_eff_last;
   logic run_ok;

   assign accept = start && !busy_ff;
   assign idx_end = (idx_ff == nlast_ff);
   assign csr_ready = 1'b1;

   // clamp node count into 1..MAX_NODES
   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = dsp_pkg::CNT_W'(1);
      end else if (node_count_ff > dsp_pkg::CNT_W'(MAX_NODES)) begin
         n_eff = dsp_pkg::CNT_W'(MAX_NODES);
      end else begin
         n_eff = node_count_ff;
      end
   end

   assign n_eff_last = dsp_pkg::IDX_W'(n_eff - dsp_pkg::CNT_W'(1));
   assign run_ok = ({1'b0, source_ff} < n_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= dsp_pkg::CNT_W'(64);
         source_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dsp_pkg::CSR_NODE_COUNT: node_count_ff <= csr_wdata;
            dsp_pkg::CSR_SOURCE:     source_ff <= csr_wdata[dsp_pkg::IDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = dsp_pkg::OP_NONE;
      idx_in = idx_ff;
      nlast_in = nlast_ff;
      src_in = src_ff;
      last_in = 1'b0;
      ok_in = ok_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_op == dsp_pkg::REQ_RUN) begin
               nlast_in = n_eff_last;
               src_in = source_ff;
               ok_in = run_ok;
               idx_in = '0;
               if (run_ok) begin
                  state_in = S_INIT;
                  op_in = dsp_pkg::OP_INIT;
               end else begin
                  state_in = S_EMIT;
                  op_in = dsp_pkg::OP_EMIT;
                  last_in = (n_eff_last == '0);
               end
            end
         end
         S_INIT: begin
            if (idx_end) begin
               state_in = S_CLEAR;
               op_in = dsp_pkg::OP_CLEAR;
            end else begin
               idx_in = idx_ff + dsp_pkg::IDX_W'(1);
               op_in = dsp_pkg::OP_INIT;
            end
         end
         S_CLEAR: begin
            state_in = S_SCAN;
            op_in = dsp_pkg::OP_SCAN;
            idx_in = '0;
         end
         S_SCAN: begin
            if (idx_end) begin
               state_in = S_WAIT;
            end else begin
               idx_in = idx_ff + dsp_pkg::IDX_W'(1);
               op_in = dsp_pkg::OP_SCAN;
            end
         end
         S_WAIT: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            idx_in = '0;
            if (status.found) begin
               state_in = S_RELAX;
               op_in = dsp_pkg::OP_RELAX;
            end else begin
               state_in = S_EMIT;
               op_in = dsp_pkg::OP_EMIT;
               last_in = (nlast_ff == '0);
            end
         end
         S_RELAX: begin
            if (idx_end) begin
               state_in = S_CLEAR;
               op_in = dsp_pkg::OP_CLEAR;
            end else begin
               idx_in = idx_ff + dsp_pkg::IDX_W'(1);
               op_in = dsp_pkg::OP_RELAX;
            end
         end
         S_EMIT: begin
            if (idx_end) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + dsp_pkg::IDX_W'(1);
               op_in = dsp_pkg::OP_EMIT;
               last_in = ((idx_ff + dsp_pkg::IDX_W'(1)) == nlast_ff);
            end
         end
         default: state_in = S_IDLE;
      endcase
      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= dsp_pkg::OP_NONE;
         busy_ff <= 1'b0;
         idx_ff <= '0;
         nlast_ff <= '0;
         src_ff <= '0;
         last_ff <= 1'b0;
         ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         busy_ff <= busy_in;
         idx_ff <= idx_in;
         nlast_ff <= nlast_in;
         src_ff <= src_in;
         last_ff <= last_in;
         ok_ff <= ok_in;
      end
   end

   assign busy = busy_ff;

   assign cmd = '{
      load: accept && (req_op == dsp_pkg::REQ_LOAD),
      op:   op_ff,
      idx:  idx_ff,
      src:  src_ff,
      last: last_ff,
      ok:   ok_ff
   };

endmodule

>>> rtl/dsp_datapath.sv
// weight and node memories, minimum search and relaxation arithmetic
module dsp_datapath #(
   parameter int MAX_NODES = dsp_pkg::MAX_NODES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dsp_pkg::dp_cmd_type               cmd,
   output dsp_pkg::dp_status_type            status,
   input  logic [dsp_pkg::IDX_W-1:0]         req_row,
   input  logic [dsp_pkg::IDX_W-1:0]         req_col,
   input  logic [dsp_pkg::DIST_W-1:0]        req_weight,
   output logic                              rsp_valid,
   output logic [dsp_pkg::IDX_W-1:0]         rsp_node,
   output logic [dsp_pkg::DIST_W-1:0]        rsp_distance,
   output logic                              rsp_has_predecessor,
   output logic [dsp_pkg::IDX_W-1:0]         rsp_predecessor,
   output logic                              rsp_last
);

   localparam int NAW = $clog2(MAX_NODES);
   localparam int MAW = $clog2(MAX_NODES * MAX_NODES);

   logic [dsp_pkg::DIST_W-1:0] mat_mem [MAX_NODES * MAX_NODES];
   dsp_pkg::node_entry_type node_mem [MAX_NODES];

   logic [dsp_pkg::DIST_W-1:0] mat_rd_ff;
   dsp_pkg::node_entry_type node_rd_ff;

   dsp_pkg::dp_op_type op_q_ff;
   logic [dsp_pkg::IDX_W-1:0] idx_q_ff;
   logic last_q_ff;
   logic ok_q_ff;

   logic [dsp_pkg::DIST_W-1:0] best_ff;
   logic [dsp_pkg::IDX_W-1:0] u_ff;
   logic found_ff;

   logic rsp_valid_ff;
   logic [dsp_pkg::IDX_W-1:0] rsp_node_ff;
   logic [dsp_pkg::DIST_W-1:0] rsp_distance_ff;
   logic rsp_has_pred_ff;
   logic [dsp_pkg::IDX_W-1:0] rsp_pred_ff;
   logic rsp_last_ff;

   logic load_in_range;
   logic [MAW-1:0] mat_waddr;
   logic [dsp_pkg::IDX_W-1:0] rd_row;
   logic [MAW-1:0] mat_raddr;
   logic [dsp_pkg::DIST_W:0] relax_sum;
   logic relax_take;
   logic node_we;
   dsp_pkg::node_entry_type node_wr;

   assign load_in_range = ({1'b0, req_row} < (dsp_pkg::IDX_W + 1)'(MAX_NODES))
                       && ({1'b0, req_col} < (dsp_pkg::IDX_W + 1)'(MAX_NODES));
   assign mat_waddr = MAW'(req_row) * MAW'(MAX_NODES) + MAW'(req_col);

   // init walks the source row, relax walks the row of the chosen node
   assign rd_row = (cmd.op == dsp_pkg::OP_INIT) ? cmd.src : u_ff;
   assign mat_raddr = MAW'(rd_row) * MAW'(MAX_NODES) + MAW'(cmd.idx);

   always_ff @(posedge clock) begin
      if (cmd.load && load_in_range) begin
         mat_mem[mat_waddr] <= req_weight;
      end
      mat_rd_ff <= mat_mem[mat_raddr];
   end

   // relaxation of one neighbor, using the registered reads
   assign relax_sum = {1'b0, best_ff} + {1'b0, mat_rd_ff};
   assign relax_take = !node_rd_ff.visited && (mat_rd_ff != dsp_pkg::NO_EDGE)
                    && (relax_sum < {1'b0, node_rd_ff.path_len});

   always_comb begin
      node_we = 1'b0;
      node_wr = node_rd_ff;
      case (op_q_ff)
         dsp_pkg::OP_INIT: begin
            node_we = 1'b1;
            node_wr.path_len = mat_rd_ff;
            node_wr.visited = (idx_q_ff == cmd.src);
            node_wr.pred_valid = (idx_q_ff != cmd.src) && (mat_rd_ff != dsp_pkg::NO_EDGE);
            node_wr.pred = cmd.src;
         end
         dsp_pkg::OP_RELAX: begin
            node_we = 1'b1;
            node_wr.visited = node_rd_ff.visited || (idx_q_ff == u_ff);
            if (relax_take) begin
               node_wr.path_len = relax_sum[dsp_pkg::DIST_W-1:0];
               node_wr.pred_valid = 1'b1;
               node_wr.pred = u_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[idx_q_ff[NAW-1:0]] <= node_wr;
      end
      node_rd_ff <= node_mem[cmd.idx[NAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_q_ff <= dsp_pkg::OP_NONE;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op_q_ff <= cmd.op;
         if (cmd.op == dsp_pkg::OP_CLEAR) begin
            found_ff <= 1'b0;
         end else if (op_q_ff == dsp_pkg::OP_SCAN && !node_rd_ff.visited
                      && node_rd_ff.path_len < best_ff) begin
            found_ff <= 1'b1;
         end
         rsp_valid_ff <= (op_q_ff == dsp_pkg::OP_EMIT);
      end
   end

   always_ff @(posedge clock) begin
      idx_q_ff <= cmd.idx;
      last_q_ff <= cmd.last;
      ok_q_ff <= cmd.ok;
      // strict compare keeps the lowest index on ties
      if (cmd.op == dsp_pkg::OP_CLEAR) begin
         best_ff <= dsp_pkg::NO_EDGE;
      end else if (op_q_ff == dsp_pkg::OP_SCAN && !node_rd_ff.visited
                   && node_rd_ff.path_len < best_ff) begin
         best_ff <= node_rd_ff.path_len;
         u_ff <= idx_q_ff;
      end
      rsp_node_ff <= idx_q_ff;
      rsp_last_ff <= last_q_ff;
      rsp_distance_ff <= ok_q_ff ? node_rd_ff.path_len : dsp_pkg::NO_EDGE;
      rsp_has_pred_ff <= ok_q_ff && node_rd_ff.pred_valid;
      rsp_pred_ff <= (ok_q_ff && node_rd_ff.pred_valid) ? node_rd_ff.pred : '0;
   end

   assign status = '{found: found_ff};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_node = rsp_node_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_has_predecessor = rsp_has_pred_ff;
   assign rsp_predecessor = rsp_pred_ff;
   assign rsp_last = rsp_last_ff;

endmodule

>>> rtl/dense_shortest_path_core.sv
// top level: dense adjacency-matrix shortest path engine
// loads may follow each other every cycle while busy is low
// a run is an init pass over the nodes, then clear / scan / decide passes, each followed by a
// relax pass while a node is found, then an emit pass; the memories are read one entry per cycle
// results stream out one per cycle and the last one comes after busy falls; the receiver cannot stall
// synchronous active-high reset clears control and config (node_count 64, source 0), not the memories
`include "dense_shortest_path_core_defines.svh"

module dense_shortest_path_core #(
   parameter int MAX_NODES = dsp_pkg::MAX_NODES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // command transfer: taken when start is high and busy is low
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_op,
   input  logic [dsp_pkg::IDX_W-1:0]         req_row,
   input  logic [dsp_pkg::IDX_W-1:0]         req_col,
   input  logic [dsp_pkg::DIST_W-1:0]        req_weight,
   // result stream, one strobe per node
   output logic                              rsp_valid,
   output logic [dsp_pkg::IDX_W-1:0]         rsp_node,
   output logic [dsp_pkg::DIST_W-1:0]        rsp_distance,
   output logic                              rsp_has_predecessor,
   output logic [dsp_pkg::IDX_W-1:0]         rsp_predecessor,
   output logic                              rsp_last,
   // register write port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dsp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dsp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // command and status between sequencer and datapath
   dsp_pkg::dp_cmd_type cmd;
   dsp_pkg::dp_status_type status;

   // sequencer: init, repeated clear/scan/decide/relax passes, emit; bad source: straight to emit
   dsp_ctrl #(
      .MAX_NODES (MAX_NODES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_op),
      .busy      (busy),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: matrix memory, node table, min search and relaxation
   dsp_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_row             (req_row),
      .req_col             (req_col),
      .req_weight          (req_weight),
      .rsp_valid           (rsp_valid),
      .rsp_node            (rsp_node),
      .rsp_distance        (rsp_distance),
      .rsp_has_predecessor (rsp_has_predecessor),
      .rsp_predecessor     (rsp_predecessor),
      .rsp_last            (rsp_last)
   );

   // a run transfer always makes the core busy in the next cycle
   `DSP_ASSERT_NEXT(a_run_sets_busy, clock, reset, start && !busy && (req_op == dsp_pkg::REQ_RUN), busy)
   // nothing is strobed right after the final node
   `DSP_ASSERT_NEXT(a_last_ends_burst, clock, reset, rsp_valid && rsp_last, !rsp_valid)
   // results come back to back in node order until the final one
   `DSP_ASSERT_NEXT(a_burst_in_order, clock, reset, rsp_valid && !rsp_last, rsp_valid && (rsp_node == 6'($past(rsp_node) + 6'd1)))
   // an absent predecessor always reads as zero
   `DSP_ASSERT_SAME(a_no_pred_zero, clock, reset, rsp_valid && !rsp_has_predecessor, rsp_predecessor == '0)

endmodule
